>>> hdl/htri_pkg.sv
`default_nettype none

package htri_pkg;

	localparam int GRID_COLS_DEF = 64;
	localparam int GRID_ROWS_DEF = 64;
	localparam int FRAC_BITS_DEF = 8;

	localparam int ELEV_W  = 8;
	localparam int WIDX_W  = 6;
	localparam int COORD_W = 16;
	localparam int HOUT_W  = 16;

	localparam logic [HOUT_W-1:0] HEIGHT_MAX = 16'hFF00;

	localparam logic FUNC_STORE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// corner routing: parity bits of the clamped indices pick the bank
	typedef struct packed {
		logic upper;
		logic px0;
		logic px1;
		logic pz0;
		logic pz1;
	} htri_sel_t;

endpackage

`default_nettype wire

>>> hdl/htri_ram.sv
`default_nettype none

module htri_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 1024,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/htri_front.sv
`default_nettype none

module htri_front #(
	parameter  int GRID_COLS = htri_pkg::GRID_COLS_DEF,
	parameter  int GRID_ROWS = htri_pkg::GRID_ROWS_DEF,
	parameter  int FRAC_BITS = htri_pkg::FRAC_BITS_DEF,
	localparam int HC        = (GRID_COLS + 1) / 2,
	localparam int HR        = (GRID_ROWS + 1) / 2,
	localparam int BANK_D    = HC * HR,
	localparam int AW        = (BANK_D > 1) ? $clog2(BANK_D) : 1,
	localparam int WT_W      = FRAC_BITS + 1
) (
	input  logic signed [htri_pkg::COORD_W-1:0] query_col,
	input  logic signed [htri_pkg::COORD_W-1:0] query_row,
	output logic [3:0][AW-1:0]                  rd_addr,
	output htri_pkg::htri_sel_t                 sel,
	output logic [WT_W-1:0]                     wa,
	output logic [WT_W-1:0]                     wb
);

	import htri_pkg::*;

	localparam int COL_W = $clog2(GRID_COLS);
	localparam int ROW_W = $clog2(GRID_ROWS);
	localparam logic [WT_W-1:0] ONE = WT_W'(2 ** FRAC_BITS);

	function automatic logic [11:0] clamp_i(input logic signed [17:0] v,
		input logic signed [17:0] hi);
		logic [11:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > hi) begin
			r = hi[11:0];
		end else begin
			r = v[11:0];
		end
		return r;
	endfunction

	logic signed [16:0] nx, nz;
	logic signed [17:0] nx1, nz1;
	logic [COL_W-1:0] c0, c1, col_b;
	logic [ROW_W-1:0] r0, r1, row_b;
	logic [FRAC_BITS-1:0] dx, dz;
	logic [WT_W-1:0] dsum;
	logic upper;

	always_comb begin
		nx  = $signed({query_col[COORD_W-1], query_col}) >>> FRAC_BITS;
		nz  = $signed({query_row[COORD_W-1], query_row}) >>> FRAC_BITS;
		nx1 = $signed({nx[16], nx}) + 18'sd1;
		nz1 = $signed({nz[16], nz}) + 18'sd1;
		c0  = COL_W'(clamp_i({nx[16], nx}, 18'(GRID_COLS - 1)));
		c1  = COL_W'(clamp_i(nx1, 18'(GRID_COLS - 1)));
		r0  = ROW_W'(clamp_i({nz[16], nz}, 18'(GRID_ROWS - 1)));
		r1  = ROW_W'(clamp_i(nz1, 18'(GRID_ROWS - 1)));

		dx    = query_col[FRAC_BITS-1:0];
		dz    = query_row[FRAC_BITS-1:0];
		dsum  = {1'b0, dx} + {1'b0, dz};
		upper = dsum > ONE;
		wa    = upper ? (ONE - {1'b0, dz}) : {1'b0, dx};
		wb    = upper ? (ONE - {1'b0, dx}) : {1'b0, dz};

		sel.upper = upper;
		sel.px0   = c0[0];
		sel.px1   = c1[0];
		sel.pz0   = r0[0];
		sel.pz1   = r1[0];
	end

	// bank index = {row parity, col parity}
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			col_b = (c0[0] == b[0]) ? c0 : c1;
			row_b = (r0[0] == b[1]) ? r0 : r1;
			rd_addr[b] = AW'(24'(row_b >> 1) * 24'(HC) + 24'(col_b >> 1));
		end
	end

endmodule

`default_nettype wire

>>> hdl/htri_blend.sv
`default_nettype none

module htri_blend #(
	parameter  int FRAC_BITS = htri_pkg::FRAC_BITS_DEF,
	localparam int WT_W      = FRAC_BITS + 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   valid_s1,
	input  htri_pkg::htri_sel_t                    sel_s1,
	input  logic [WT_W-1:0]                        wa_s1,
	input  logic [WT_W-1:0]                        wb_s1,
	input  logic [3:0][htri_pkg::ELEV_W-1:0]       rd_data,
	output logic                                   strobe,
	output logic [htri_pkg::HOUT_W-1:0]            height_out
);

	import htri_pkg::*;

	localparam int VW  = FRAC_BITS + 11;
	localparam int SW  = VW + 8;
	localparam int RND = (2 ** FRAC_BITS) / 512;
	localparam int DN  = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
	localparam int UP  = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;

	logic [ELEV_W-1:0] c00, c10, c01, c11, base;
	logic signed [8:0] ea, eb;
	logic signed [VW-1:0] pa, pb, bt, v;
	logic signed [VW-1:0] v_s2;
	logic valid_s2;
	logic [VW-1:0] vu;
	logic [SW-1:0] scl;
	logic strobe_q;
	logic [HOUT_W-1:0] height_q;

	always_comb begin
		c00  = rd_data[{sel_s1.pz0, sel_s1.px0}];
		c10  = rd_data[{sel_s1.pz0, sel_s1.px1}];
		c01  = rd_data[{sel_s1.pz1, sel_s1.px0}];
		c11  = rd_data[{sel_s1.pz1, sel_s1.px1}];
		base = sel_s1.upper ? c11 : c00;
		ea   = $signed({1'b0, c10}) - $signed({1'b0, base});
		eb   = $signed({1'b0, c01}) - $signed({1'b0, base});
		pa   = VW'(ea) * $signed(VW'(wa_s1));
		pb   = VW'(eb) * $signed(VW'(wb_s1));
		bt   = $signed(VW'({base, {FRAC_BITS{1'b0}}}));
		v    = bt + pa + pb;
	end

	always_comb begin
		vu  = v_s2[VW-1] ? '0 : v_s2;
		scl = ((SW'(vu) + SW'(RND)) >> DN) << UP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			strobe_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		v_s2     <= v;
		height_q <= (scl > SW'(HEIGHT_MAX)) ? HEIGHT_MAX : scl[HOUT_W-1:0];
	end

	assign strobe     = strobe_q;
	assign height_out = height_q;

endmodule

`default_nettype wire

>>> hdl/heightmap_triangle_interp.sv
// A query accepted at one clock edge shows its beat on strobe/height_out after
// passing the bank read, the blend stage and the output register, in that order.
// Throughput: one beat per clock; stores and queries may follow back to back,
// the four parity banks give all corner reads of a query in the same cycle.
// busy stays low; the receiver cannot stall. Reset clears the pipeline valid
// bits; the grid memory is not cleared and holds nothing defined until written.
`default_nettype none

module heightmap_triangle_interp #(
	parameter int GRID_COLS = htri_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = htri_pkg::GRID_ROWS_DEF,
	parameter int FRAC_BITS = htri_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               func,
	input  logic [htri_pkg::WIDX_W-1:0]        write_col,
	input  logic [htri_pkg::WIDX_W-1:0]        write_row,
	input  logic [htri_pkg::ELEV_W-1:0]        write_elev,
	input  logic signed [htri_pkg::COORD_W-1:0] query_col,
	input  logic signed [htri_pkg::COORD_W-1:0] query_row,
	output logic                               strobe,
	output logic [htri_pkg::HOUT_W-1:0]        height_out
);

	import htri_pkg::*;

	localparam int HC     = (GRID_COLS + 1) / 2;
	localparam int HR     = (GRID_ROWS + 1) / 2;
	localparam int BANK_D = HC * HR;
	localparam int AW     = (BANK_D > 1) ? $clog2(BANK_D) : 1;
	localparam int COL_W  = $clog2(GRID_COLS);
	localparam int ROW_W  = $clog2(GRID_ROWS);
	localparam int WT_W   = FRAC_BITS + 1;

	logic accept, wr_ok;
	logic [COL_W-1:0] wc;
	logic [ROW_W-1:0] wr;
	logic [1:0] wbank;
	logic [AW-1:0] waddr;
	logic [3:0][AW-1:0] rd_addr;
	logic [3:0][ELEV_W-1:0] rd_data;
	htri_sel_t sel, sel_s1;
	logic [WT_W-1:0] wa, wb, wa_s1, wb_s1;
	logic valid_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		wc    = COL_W'(write_col);
		wr    = ROW_W'(write_row);
		wr_ok = accept && (func == FUNC_STORE)
			&& (13'(write_col) < 13'(GRID_COLS)) && (13'(write_row) < 13'(GRID_ROWS));
		wbank = {wr[0], wc[0]};
		waddr = AW'(24'(wr >> 1) * 24'(HC) + 24'(wc >> 1));
	end

	htri_front #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.query_col(query_col),
		.query_row(query_row),
		.rd_addr  (rd_addr),
		.sel      (sel),
		.wa       (wa),
		.wb       (wb)
	);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		htri_ram #(
			.WIDTH(ELEV_W),
			.DEPTH(BANK_D)
		) u_ram (
			.clk  (clk),
			.we   (wr_ok && (wbank == 2'(b))),
			.waddr(waddr),
			.wdata(write_elev),
			.raddr(rd_addr[b]),
			.rdata(rd_data[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (func == FUNC_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		sel_s1 <= sel;
		wa_s1  <= wa;
		wb_s1  <= wb;
	end

	htri_blend #(
		.FRAC_BITS(FRAC_BITS)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.sel_s1    (sel_s1),
		.wa_s1     (wa_s1),
		.wb_s1     (wb_s1),
		.rd_data   (rd_data),
		.strobe    (strobe),
		.height_out(height_out)
	);

endmodule

`default_nettype wire

>>> hdl/htri_check.sv
`default_nettype none

module htri_check (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         start,
	input wire                         busy,
	input wire                         func,
	input wire                         strobe,
	input wire [htri_pkg::HOUT_W-1:0]  height_out
);

	import htri_pkg::*;

	// every accepted query gets its beat on strobe
	a_query_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FUNC_QUERY)) |-> ##3 strobe)
		else $error("query beat missing");

	// no beat without an earlier accepted query
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy && (func == FUNC_QUERY), 3))
		else $error("beat without query");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (height_out <= HEIGHT_MAX))
		else $error("height out of range");

endmodule

bind heightmap_triangle_interp htri_check u_htri_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.func      (func),
	.strobe    (strobe),
	.height_out(height_out)
);

`default_nettype wire
